// ===== sv/btmx_pkg.sv =====
// Shared types and codes for the binary trie maximum-XOR block.
package btmx_pkg;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POOL_FULL = 2'd1,
      STATUS_EMPTY     = 2'd2
   } btmx_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHECK,
      ST_ALLOC,
      ST_SEAL,
      ST_DONE
   } btmx_state_type;

   typedef struct packed {
      logic            load;
      logic            walk;
      logic            alloc;
      logic            seal;
      logic            set_status;
      btmx_status_type status_code;
      logic            publish;
   } btmx_cmd_type;

   typedef struct packed {
      logic root_empty;
      logic is_query;
      logic stop;
      logic last;
      logic pool_full;
   } btmx_flags_type;

endpackage

// ===== sv/btmx_ram.sv =====
// Generic single-port RAM with registered read data.
module btmx_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/btmx_control.sv =====
// Controller state machine that sequences trie walks, allocation and result handoff.
module btmx_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  btmx_pkg::btmx_flags_type flags,
   output btmx_pkg::btmx_cmd_type   cmd
);

   import btmx_pkg::*;

   btmx_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = STATUS_OK;
      out_free        = !rsp_valid_ff || rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tuser == ACTION_QUERY && flags.root_empty) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STATUS_EMPTY;
                  state_in        = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (flags.is_query) begin
               if (flags.stop || flags.last) begin
                  state_in = ST_DONE;
               end
            end else if (flags.stop) begin
               state_in = ST_CHECK;
            end else if (flags.last) begin
               state_in = ST_DONE;
            end
         end
         ST_CHECK: begin
            if (flags.pool_full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_POOL_FULL;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            if (flags.last) begin
               state_in = ST_SEAL;
            end
         end
         ST_SEAL: begin
            cmd.seal = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_tready);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/btmx_datapath.sv =====
// Datapath with the node memories, root links, free pointer, walk registers and result register.
module btmx_datapath #(
   parameter int KEY_BITS   = 43,
   parameter int POOL_NODES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [KEY_BITS-1:0]       req_key,
   input  logic                      req_action,
   input  btmx_pkg::btmx_cmd_type    cmd,
   output btmx_pkg::btmx_flags_type  flags,
   output logic [KEY_BITS-1:0]       best_xor,
   output btmx_pkg::btmx_status_type status
);

   import btmx_pkg::*;

   localparam int NODE_W = $clog2(POOL_NODES);
   localparam int CNT_W  = $clog2(POOL_NODES + 1);
   localparam int LVL_W  = $clog2(KEY_BITS);
   localparam int SUM_W  = CNT_W + LVL_W + 1;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] weight_ff, weight_in;
   logic [KEY_BITS-1:0] acc_ff, acc_in;
   logic [KEY_BITS-1:0] best_ff, best_in;
   logic                is_query_ff, is_query_in;
   logic                fresh_ff, fresh_in;
   logic [LVL_W-1:0]    level_ff, level_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [NODE_W-1:0]   root_zero_ff, root_zero_in;
   logic [NODE_W-1:0]   root_one_ff, root_one_in;
   logic [CNT_W-1:0]    next_free_ff, next_free_in;
   btmx_status_type     status_ff, status_in;
   btmx_status_type     rsp_status_ff, rsp_status_in;

   logic                zero_we, one_we;
   logic [NODE_W-1:0]   ram_addr;
   logic [NODE_W-1:0]   zero_wdata, one_wdata;
   logic [NODE_W-1:0]   zero_rdata, one_rdata;

   logic                at_root;
   logic                key_bit;
   logic [NODE_W-1:0]   cur_zero, cur_one;
   logic [NODE_W-1:0]   want, same, walk_next, fresh_node;
   logic                take_want;
   logic                stop;
   logic [SUM_W-1:0]    missing, need_total;

   btmx_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_zero_ram (
      .clock (clock),
      .we    (zero_we),
      .addr  (ram_addr),
      .wdata (zero_wdata),
      .rdata (zero_rdata)
   );

   btmx_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_one_ram (
      .clock (clock),
      .we    (one_we),
      .addr  (ram_addr),
      .wdata (one_wdata),
      .rdata (one_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= CNT_W'(1);
         root_zero_ff <= '0;
         root_one_ff  <= '0;
      end else begin
         next_free_ff <= next_free_in;
         root_zero_ff <= root_zero_in;
         root_one_ff  <= root_one_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      weight_ff     <= weight_in;
      acc_ff        <= acc_in;
      best_ff       <= best_in;
      is_query_ff   <= is_query_in;
      fresh_ff      <= fresh_in;
      level_ff      <= level_in;
      node_ff       <= node_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      at_root    = (level_ff == '0);
      key_bit    = key_ff[KEY_BITS-1];
      cur_zero   = at_root ? root_zero_ff : zero_rdata;
      cur_one    = at_root ? root_one_ff : one_rdata;
      want       = key_bit ? cur_zero : cur_one;
      same       = key_bit ? cur_one : cur_zero;
      take_want  = is_query_ff && (want != '0);
      walk_next  = take_want ? want : same;
      stop       = (walk_next == '0);
      fresh_node = next_free_ff[NODE_W-1:0];
      missing    = SUM_W'(KEY_BITS) - SUM_W'(level_ff);
      need_total = SUM_W'(next_free_ff) + missing;

      flags.root_empty = (root_zero_ff == '0) && (root_one_ff == '0);
      flags.is_query   = is_query_ff;
      flags.stop       = stop;
      flags.last       = (level_ff == LVL_W'(KEY_BITS - 1));
      flags.pool_full  = (need_total > SUM_W'(POOL_NODES));
   end

   always_comb begin
      key_in        = key_ff;
      weight_in     = weight_ff;
      acc_in        = acc_ff;
      best_in       = best_ff;
      is_query_in   = is_query_ff;
      fresh_in      = fresh_ff;
      level_in      = level_ff;
      node_in       = node_ff;
      next_free_in  = next_free_ff;
      root_zero_in  = root_zero_ff;
      root_one_in   = root_one_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      zero_we       = 1'b0;
      one_we        = 1'b0;
      zero_wdata    = '0;
      one_wdata     = '0;
      ram_addr      = cmd.walk ? walk_next : node_ff;

      if (cmd.load) begin
         key_in                = req_key;
         is_query_in           = (req_action == ACTION_QUERY);
         level_in              = '0;
         node_in               = '0;
         weight_in             = '0;
         weight_in[KEY_BITS-1] = 1'b1;
         acc_in                = '0;
         fresh_in              = 1'b0;
      end

      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end else if (cmd.load) begin
         status_in = STATUS_OK;
      end

      if (cmd.walk && !stop) begin
         node_in   = walk_next;
         level_in  = level_ff + LVL_W'(1);
         key_in    = key_ff << 1;
         weight_in = weight_ff >> 1;
         if (take_want) begin
            acc_in = acc_ff | weight_ff;
         end
      end

      if (cmd.alloc) begin
         if (at_root) begin
            if (key_bit) begin
               root_one_in = fresh_node;
            end else begin
               root_zero_in = fresh_node;
            end
         end else if (key_bit) begin
            one_we     = 1'b1;
            one_wdata  = fresh_node;
            zero_we    = fresh_ff;
         end else begin
            zero_we    = 1'b1;
            zero_wdata = fresh_node;
            one_we     = fresh_ff;
         end
         node_in      = fresh_node;
         level_in     = level_ff + LVL_W'(1);
         key_in       = key_ff << 1;
         next_free_in = next_free_ff + CNT_W'(1);
         fresh_in     = 1'b1;
      end

      if (cmd.seal) begin
         zero_we = 1'b1;
         one_we  = 1'b1;
      end

      if (cmd.publish) begin
         best_in       = acc_ff;
         rsp_status_in = status_ff;
      end
   end

   assign best_xor = best_ff;
   assign status   = rsp_status_ff;

endmodule

// ===== sv/binary_trie_max_xor.sv =====
// Top level of the binary trie maximum-XOR engine: control, datapath and checks.
//
//   Channel | Direction | tdata (low bit up)        | tuser
//   req     | in        | key, zero padding         | action (0 insert, 1 query)
//   rsp     | out       | best_xor, zero padding    | status (0 ok, 1 pool full, 2 empty)
//
// The node memory loop descends one trie level per cycle and allocates one node per cycle;
// at reset, root links and the free pointer sit in flip-flops and every other node is
// written when it is allocated, so the memories need no clearing pass.
// One transaction is in flight at a time; a finished result waits in the output register
// while the next request is accepted, and the engine stalls only if that register is full.
module binary_trie_max_xor #(
   parameter int KEY_BITS   = 43,
   parameter int POOL_NODES = 4096,
   localparam int DATA_W    = ((KEY_BITS + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // key, then zero padding
   input  logic              req_tuser,   // action
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // best_xor, then zero padding
   output logic [1:0]        rsp_tuser    // status
);

   import btmx_pkg::*;

   btmx_cmd_type        cmd;
   btmx_flags_type      flags;
   logic [KEY_BITS-1:0] best_xor;
   btmx_status_type     status;

   btmx_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   btmx_datapath #(.KEY_BITS(KEY_BITS), .POOL_NODES(POOL_NODES)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_key    (req_tdata[KEY_BITS-1:0]),
      .req_action (req_tuser),
      .cmd        (cmd),
      .flags      (flags),
      .best_xor   (best_xor),
      .status     (status)
   );

   assign rsp_tdata = DATA_W'(best_xor);
   assign rsp_tuser = status;

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_tvalid || rsp_tready))
      else $error("Result register overwritten before its transaction completed.");

   a_alloc_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> !flags.pool_full)
      else $error("Node allocation runs past the end of the pool.");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_EMPTY) |-> (rsp_tdata == '0))
      else $error("Query on an empty set returned a nonzero result.");

endmodule
